// File: rtl/fpba_pkg.sv
package fpba_pkg;

  localparam int NUM_BLOCKS   = 16;
  localparam int SIZE_WIDTH   = 16;
  localparam int BLK_IDX_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LIMIT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_FIELD_W   = 1;
  localparam int BLOCK_FIELD_W  = 4;
  localparam int SIZE_FIELD_W   = 16;
  localparam int POLICY_W       = 2;
  localparam int COUNT_W        = 5;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 5;

  localparam logic [MODE_FIELD_W-1:0] MODE_LOAD    = 1'b0;
  localparam logic [MODE_FIELD_W-1:0] MODE_REQUEST = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [POLICY_W-1:0] FIT_POLICY_RESET  = POLICY_FIRST;
  localparam logic [COUNT_W-1:0]  BLOCK_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [MODE_FIELD_W-1:0]  mode;
    logic [BLOCK_FIELD_W-1:0] block_index;
    logic [SIZE_FIELD_W-1:0]  size_value;
  } in_item_t;

  typedef struct packed {
    logic                     granted;
    logic [BLOCK_FIELD_W-1:0] granted_block;
    logic [SIZE_FIELD_W-1:0]  remaining_size;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_REQUEST = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [BLK_IDX_W-1:0]   idx;
    logic [SIZE_WIDTH-1:0]  size;
  } cmd_t;

endpackage

// File: rtl/fit_policy_block_allocator.sv
// A request scans N table entries, N the number of blocks scanned (block_count
// capped at NUM_BLOCKS, fewer when first fit stops early).
// The table scan examines one entry per cycle; the back end takes no new command
// until a request has passed ST_FINISH. A two-entry queue decouples front and back.
// Reset: synchronous, clears every block size to zero, fit_policy to first fit
// and block_count to 16; no clearing pass follows.
module fit_policy_block_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fpba_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fpba_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [fpba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [fpba_pkg::POLICY_W-1:0] fit_policy;
  logic [fpba_pkg::COUNT_W-1:0]  block_count;
  logic                          push_valid;
  logic                          push_ready;
  fpba_pkg::cmd_t                push_cmd;
  logic                          q_valid;
  logic                          q_pop;
  fpba_pkg::cmd_t                q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= fpba_pkg::FIT_POLICY_RESET;
      block_count <= fpba_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::CFG_FIT_POLICY: begin
          fit_policy <= cfg_data[fpba_pkg::POLICY_W-1:0];
        end
        fpba_pkg::CFG_BLOCK_COUNT: begin
          block_count <= cfg_data[fpba_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fpba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fpba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  fpba_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .fit_policy  (fit_policy),
    .block_count (block_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: rtl/fpba_front.sv
module fpba_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpba_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output fpba_pkg::cmd_t     push_cmd
);

  logic           hold_valid;
  fpba_pkg::cmd_t hold_cmd;
  fpba_pkg::cmd_t cls_cmd;
  logic           accept;
  logic           push;

  always_comb begin
    cls_cmd.idx  = fpba_pkg::BLK_IDX_W'(in_data.block_index);
    cls_cmd.size = fpba_pkg::SIZE_WIDTH'(in_data.size_value);
    if (in_data.mode == fpba_pkg::MODE_REQUEST) begin
      cls_cmd.op = fpba_pkg::CMD_REQUEST;
    end else if (32'(in_data.block_index) < fpba_pkg::NUM_BLOCKS) begin
      cls_cmd.op = fpba_pkg::CMD_LOAD;
    end else begin
      cls_cmd.op = fpba_pkg::CMD_NONE;
    end
  end

  assign push       = hold_valid && push_ready;
  assign in_ready   = !hold_valid || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept && cls_cmd.op != fpba_pkg::CMD_NONE) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= cls_cmd;
    end
  end

endmodule

// File: rtl/fpba_queue.sv
module fpba_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fpba_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output fpba_pkg::cmd_t pop_cmd
);

  fpba_pkg::cmd_t                entries [fpba_pkg::QUEUE_DEPTH];
  logic [fpba_pkg::QPTR_W-1:0]  wr_ptr;
  logic [fpba_pkg::QPTR_W-1:0]  rd_ptr;
  logic [fpba_pkg::QCNT_W-1:0]  count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (32'(count) < fpba_pkg::QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [fpba_pkg::QPTR_W-1:0] wrap_inc(
    input logic [fpba_pkg::QPTR_W-1:0] p
  );
    if (32'(p) == fpba_pkg::QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/fpba_back.sv
module fpba_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  fpba_pkg::cmd_t                     q_cmd,
  input  logic [fpba_pkg::POLICY_W-1:0]      fit_policy,
  input  logic [fpba_pkg::COUNT_W-1:0]       block_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fpba_pkg::out_item_t                out_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                             state;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    block_remaining [fpba_pkg::NUM_BLOCKS];
  logic                               found;
  logic [fpba_pkg::BLK_IDX_W-1:0]     chosen;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    best;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    req_size;
  logic [fpba_pkg::BLK_IDX_W-1:0]     scan_idx;
  logic [fpba_pkg::BLK_IDX_W-1:0]     last_idx;

  logic [fpba_pkg::LIMIT_W-1:0]       limit;
  logic [fpba_pkg::LIMIT_W-1:0]       limit_m1;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    scan_size;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    remain;
  logic                               qual;
  logic                               is_best;
  logic                               is_worst;
  logic                               take;
  logic                               stop_first;
  logic                               out_free;

  assign limit      = (32'(block_count) > fpba_pkg::NUM_BLOCKS) ?
                      fpba_pkg::LIMIT_W'(fpba_pkg::NUM_BLOCKS) :
                      fpba_pkg::LIMIT_W'(block_count);
  assign limit_m1   = limit - 1'b1;
  assign scan_size  = block_remaining[scan_idx];
  assign qual       = (scan_size >= req_size);
  assign is_best    = (fit_policy == fpba_pkg::POLICY_BEST);
  assign is_worst   = (fit_policy == fpba_pkg::POLICY_WORST);
  assign take       = qual && (!found || (is_best && scan_size < best) ||
                               (is_worst && scan_size > best));
  assign stop_first = qual && !found && !is_best && !is_worst;
  assign remain     = best - req_size;
  assign out_free   = !out_valid || out_ready;
  assign q_pop      = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      found     <= 1'b0;
      for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin
        block_remaining[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.op)
              fpba_pkg::CMD_LOAD: begin
                block_remaining[q_cmd.idx] <= q_cmd.size;
              end
              fpba_pkg::CMD_REQUEST: begin
                found <= 1'b0;
                state <= (limit == '0) ? ST_FINISH : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (take) begin
            found <= 1'b1;
          end
          if (stop_first || scan_idx == last_idx) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            found     <= 1'b0;
            state     <= ST_IDLE;
            if (found) begin
              block_remaining[chosen] <= remain;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req_size <= q_cmd.size;
        last_idx <= limit_m1[fpba_pkg::BLK_IDX_W-1:0];
        scan_idx <= '0;
      end
      ST_SCAN: begin
        if (take) begin
          chosen <= scan_idx;
          best   <= scan_size;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          if (found) begin
            out_data.granted        <= 1'b1;
            out_data.granted_block  <= fpba_pkg::BLOCK_FIELD_W'(chosen);
            out_data.remaining_size <= fpba_pkg::SIZE_FIELD_W'(remain);
          end else begin
            out_data <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: bench/fit_policy_block_allocator_tb.sv
`timescale 1ns / 100ps

module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t item_pending_q[$];
  out_item_t grant_expect_q[$];

  logic [SIZE_WIDTH-1:0] blk_size[NUM_BLOCKS];
  logic [POLICY_W-1:0] pol_model = FIT_POLICY_RESET;
  logic [COUNT_W-1:0] count_model = BLOCK_COUNT_RESET;

  int err_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;
  int quiet_cycles = 0;

  fit_policy_block_allocator DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    err_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void alloc_predict(input in_item_t it);
    out_item_t res;
    int lim;
    int pick;
    bit found;
    pick = 0;
    found = 1'b0;
    if (it.mode == MODE_LOAD) begin
      blk_size[it.block_index] = it.size_value;
      return;
    end
    lim = (count_model > NUM_BLOCKS) ? NUM_BLOCKS : count_model;
    for (int j = 0; j < lim; j++) begin
      if (blk_size[j] >= it.size_value) begin
        if (!found) begin
          found = 1'b1;
          pick = j;
          if (pol_model != POLICY_BEST && pol_model != POLICY_WORST) break;
        end else if (pol_model == POLICY_BEST && blk_size[j] < blk_size[pick]) begin
          pick = j;
        end else if (pol_model == POLICY_WORST && blk_size[j] > blk_size[pick]) begin
          pick = j;
        end
      end
    end
    res = '0;
    if (found) begin
      blk_size[pick] = blk_size[pick] - it.size_value;
      res.granted = 1'b1;
      res.granted_block = BLOCK_FIELD_W'(pick);
      res.remaining_size = blk_size[pick];
    end
    grant_expect_q.push_back(res);
  endfunction

  function automatic in_item_t item_of(input logic m, input logic [3:0] b,
                                       input logic [15:0] s);
    in_item_t it;
    it.mode = m;
    it.block_index = b;
    it.size_value = s;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int span;
    span = (count_model == 0 || count_model > NUM_BLOCKS) ? NUM_BLOCKS : count_model;
    it.block_index = BLOCK_FIELD_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 4) begin
      it.mode = MODE_LOAD;
      if ($urandom_range(0, 3) != 0) it.block_index = BLOCK_FIELD_W'($urandom_range(0, span - 1));
      case ($urandom_range(0, 9))
        0: it.size_value = '0;
        1: it.size_value = '1;
        2, 3: it.size_value = 16'd16 << $urandom_range(0, 2);
        4, 5, 6: it.size_value = SIZE_FIELD_W'($urandom_range(0, 255));
        default: it.size_value = SIZE_FIELD_W'($urandom);
      endcase
    end else begin
      it.mode = MODE_REQUEST;
      case ($urandom_range(0, 9))
        0: it.size_value = '0;
        1: it.size_value = SIZE_FIELD_W'($urandom);
        2: it.size_value = '1;
        default: it.size_value = SIZE_FIELD_W'($urandom_range(1, 48));
      endcase
    end
    return it;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (item_pending_q.size() != 0 || in_valid || grant_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_POLICY) pol_model = data[POLICY_W-1:0];
    else count_model = data[COUNT_W-1:0];
  endtask

  task automatic run_phase(input logic [POLICY_W-1:0] pol, input int cnt, input int n);
    wait_idle();
    cfg_write(CFG_FIT_POLICY, CFG_DATA_W'(pol));
    cfg_write(CFG_BLOCK_COUNT, CFG_DATA_W'(cnt));
    @(negedge clk);
    repeat (n) item_pending_q.push_back(rand_item());
  endtask

  initial begin
    logic [POLICY_W-1:0] pol;
    int cnt;
    foreach (blk_size[i]) blk_size[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd0));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd7, 16'd1));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd0, 16'hFFFF));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd15, 16'hFFFF));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd3, 16'd50));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd5, 16'd100));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd9, 16'd100));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd15, 16'hFFFF));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd60));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd0));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'hFFFF));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd50));
    wait_idle();
    cfg_write(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
    @(negedge clk);
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd2, 16'd30));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd11, 16'd30));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd6, 16'd80));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd25));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd31));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd0));
    wait_idle();
    cfg_write(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_WORST));
    @(negedge clk);
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd12, 16'd80));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd10));
    item_pending_q.push_back(item_of(MODE_LOAD, 4'd4, 16'd90));
    item_pending_q.push_back(item_of(MODE_REQUEST, 4'd0, 16'd0));
    run_phase(POLICY_SPARE, 16, 60);
    run_phase(POLICY_BEST, 0, 60);
    run_phase(POLICY_WORST, 31, 60);
    run_phase(POLICY_FIRST, 1, 60);
    run_phase(POLICY_BEST, 17, 60);
    repeat (10) begin
      pol = POLICY_W'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0: cnt = $urandom_range(0, 3);
        1: cnt = $urandom_range(16, 31);
        default: cnt = $urandom_range(1, 16);
      endcase
      run_phase(pol, cnt, 115);
    end
    wait_idle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) alloc_predict(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_pending_q.size() > 0) begin
          in_data <= item_pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (grant_expect_q.size() == 0) begin
          report_error($sformatf("unexpected transaction %p", out_data));
        end else begin
          want = grant_expect_q.pop_front();
          if (out_data.granted !== want.granted)
            report_error($sformatf("granted %0b, want %0b", out_data.granted, want.granted));
          if (out_data.granted_block !== want.granted_block)
            report_error($sformatf("granted_block %0d, want %0d",
                                   out_data.granted_block, want.granted_block));
          if (out_data.remaining_size !== want.remaining_size)
            report_error($sformatf("remaining_size %0d, want %0d",
                                   out_data.remaining_size, want.remaining_size));
        end
      end
      stall_cyc++;
      if (stall_cyc % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((stall_cyc % 20) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
